// ----- rtl/glyph_text_renderer_defines.svh -----
// assertion macros for the glyph text renderer
// depends on nothing; included by the top level only
`ifndef GLYPH_TEXT_RENDERER_DEFINES_SVH
`define GLYPH_TEXT_RENDERER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GTR_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("glyph text renderer assertion failed");
`define GTR_ASSERT_NXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("glyph text renderer assertion failed");
`else
`define GTR_ASSERT_IMP(label, clk, rst_n, a, b)
`define GTR_ASSERT_NXT(label, clk, rst_n, a, b)
`endif
`endif

// ----- rtl/gtr_pkg.sv -----
// shared types and constants of the glyph text renderer
// no dependencies
package gtr_pkg;

    localparam int BITMAP_BYTES_DEF  = 4096;
    localparam int GLYPH_SLOTS_DEF   = 128;
    localparam int MAX_GLYPH_DIM_DEF = 32;
    localparam int MASK_BITS         = 32;

    // request function codes
    localparam logic [1:0] FN_LOAD_BITMAP = 2'd0;
    localparam logic [1:0] FN_LOAD_GLYPH  = 2'd1;
    localparam logic [1:0] FN_SET_CURSOR  = 2'd2;
    localparam logic [1:0] FN_CHAR        = 2'd3;

    // special character codes
    localparam logic [7:0] CODE_LF = 8'h0a;
    localparam logic [7:0] CODE_CR = 8'h0d;

    // configuration register indexes
    localparam logic [2:0] CFG_TEXT_COLOR    = 3'd0;
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_WRAP_ENABLE   = 3'd3;
    localparam logic [2:0] CFG_FIRST_CODE    = 3'd4;
    localparam logic [2:0] CFG_LAST_CODE     = 3'd5;
    localparam logic [2:0] CFG_LINE_ADVANCE  = 3'd6;

    typedef struct packed {
        logic [1:0]         func;
        logic [11:0]        slot;
        logic [7:0]         byte_value;
        logic [11:0]        glyph_offset;
        logic [5:0]         glyph_width;
        logic [5:0]         glyph_height;
        logic [7:0]         glyph_advance;
        logic signed [7:0]  glyph_x_offset;
        logic signed [7:0]  glyph_y_offset;
        logic [15:0]        new_x;
        logic [15:0]        new_y;
    } t_in_item;

    typedef struct packed {
        logic [15:0] row_x;
        logic [15:0] row_y;
        logic [31:0] pixel_mask;
        logic [15:0] pixel_value;
        logic        last;
    } t_out_item;

    typedef struct packed {
        logic [11:0]       offset;
        logic [5:0]        w;
        logic [5:0]        h;
        logic [7:0]        adv;
        logic signed [7:0] xo;
        logic signed [7:0] yo;
    } t_glyph_rec;

endpackage

// ----- rtl/gtr_bitmap_store.sv -----
// font bitmap byte memory, one write and one registered read port
// depends on nothing but its parameter
module gtr_bitmap_store #(
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);
    logic [7:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- rtl/gtr_glyph_store.sv -----
// glyph record memory, one write and one registered read port
// depends on gtr_pkg
module gtr_glyph_store #(
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  gtr_pkg::t_glyph_rec      i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output gtr_pkg::t_glyph_rec      o_rdata
);
    import gtr_pkg::*;

    t_glyph_rec r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ----- rtl/glyph_text_renderer.sv -----
// Glyph text renderer. Requests are taken one at a time: load, cursor and
// ignored requests finish when accepted; a drawn character passes through the
// setup and clip states, bitmap address reduction while the glyph offset is at
// or beyond the bitmap size, then per row a fetch and load for each bitmap
// byte touched, a draw step for each byte piece and an emit step, since the
// bitmap memory delivers one byte per read. One row result leaves per emit
// cycle once the output register is free.
// Top level; depends on gtr_pkg, gtr_bitmap_store, gtr_glyph_store and the
// assertion macro header.
`include "glyph_text_renderer_defines.svh"
module glyph_text_renderer #(
    parameter int BITMAP_BYTES  = gtr_pkg::BITMAP_BYTES_DEF,
    parameter int GLYPH_SLOTS   = gtr_pkg::GLYPH_SLOTS_DEF,
    parameter int MAX_GLYPH_DIM = gtr_pkg::MAX_GLYPH_DIM_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  gtr_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output gtr_pkg::t_out_item o_out_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data
);
    import gtr_pkg::*;

    localparam int AW = $clog2(BITMAP_BYTES);
    localparam int GW = $clog2(GLYPH_SLOTS);
    localparam int DIM_CAP = (MAX_GLYPH_DIM < MASK_BITS) ? MAX_GLYPH_DIM : MASK_BITS;
    localparam logic [16:0] BB_W   = 17'(BITMAP_BYTES);
    localparam logic [8:0]  GS_W   = 9'(GLYPH_SLOTS);
    localparam logic [5:0]  CAP_W  = 6'(DIM_CAP);

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_CLIP, S_REDUCE, S_FETCH, S_LOADB, S_DRAW, S_EMIT
    } t_state;

    // configuration registers
    logic [15:0] r_text_color;
    logic [8:0]  r_screen_width;
    logic [8:0]  r_screen_height;
    logic        r_wrap_enable;
    logic [7:0]  r_first_code;
    logic [7:0]  r_last_code;
    logic [7:0]  r_line_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color    <= '0;
            r_screen_width  <= 9'd240;
            r_screen_height <= 9'd240;
            r_wrap_enable   <= 1'b0;
            r_first_code    <= 8'd32;
            r_last_code     <= 8'd126;
            r_line_advance  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEXT_COLOR:    r_text_color    <= i_cfg_data;
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data[8:0];
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[8:0];
                CFG_WRAP_ENABLE:   r_wrap_enable   <= i_cfg_data[0];
                CFG_FIRST_CODE:    r_first_code    <= i_cfg_data[7:0];
                CFG_LAST_CODE:     r_last_code     <= i_cfg_data[7:0];
                CFG_LINE_ADVANCE:  r_line_advance  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // state
    t_state      r_state, n_state;
    logic [15:0] r_col, n_col;
    logic [15:0] r_row, n_row;
    logic [5:0]  r_w, n_w;
    logic [5:0]  r_h, n_h;
    logic [7:0]  r_adv, n_adv;
    logic signed [7:0] r_xo, n_xo;
    logic signed [7:0] r_yo, n_yo;
    logic [16:0] r_addr, n_addr;
    logic [15:0] r_x0, n_x0;
    logic [15:0] r_y, n_y;
    logic [31:0] r_colmask, n_colmask;
    logic [31:0] r_mask, n_mask;
    logic [5:0]  r_xx, n_xx;
    logic [5:0]  r_yy, n_yy;
    logic [7:0]  r_bits, n_bits;
    logic [3:0]  r_left, n_left;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    // memory ports
    logic          bm_we, bm_re, gl_we, gl_re;
    logic [AW-1:0] bm_waddr;
    logic [GW-1:0] gl_addr_w, gl_addr_r;
    logic [7:0]    bm_rdata;
    t_glyph_rec    gl_wdata, gl_rdata;

    gtr_bitmap_store #(.DEPTH(BITMAP_BYTES)) u_bitmap (
        .i_clk(i_clk), .i_we(bm_we), .i_waddr(bm_waddr), .i_wdata(i_in_data.byte_value),
        .i_re(bm_re), .i_raddr(r_addr[AW-1:0]), .o_rdata(bm_rdata)
    );

    gtr_glyph_store #(.DEPTH(GLYPH_SLOTS)) u_glyph (
        .i_clk(i_clk), .i_we(gl_we), .i_waddr(gl_addr_w), .i_wdata(gl_wdata),
        .i_re(gl_re), .i_raddr(gl_addr_r), .o_rdata(gl_rdata)
    );

    // request decode
    logic       accept;
    logic [7:0] code_idx;
    logic       code_ok;
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign code_idx   = i_in_data.byte_value - r_first_code;
    assign code_ok    = (i_in_data.byte_value >= r_first_code)
                     && (i_in_data.byte_value <= r_last_code)
                     && ({1'b0, code_idx} < GS_W)
                     && (i_in_data.byte_value != CODE_LF)
                     && (i_in_data.byte_value != CODE_CR);

    assign bm_we    = accept && (i_in_data.func == FN_LOAD_BITMAP)
                   && ({5'd0, i_in_data.slot} < BB_W);
    assign bm_waddr = AW'({5'd0, i_in_data.slot});
    assign gl_we    = accept && (i_in_data.func == FN_LOAD_GLYPH)
                   && ({4'd0, i_in_data.slot} < {7'd0, GS_W[8:0]} + 13'd0);
    assign gl_addr_w = GW'(i_in_data.slot);
    assign gl_re    = accept && (i_in_data.func == FN_CHAR) && code_ok;
    assign gl_addr_r = GW'(code_idx);
    assign bm_re    = (r_state == S_FETCH);

    // saturated glyph record for loads
    always_comb begin
        gl_wdata.offset = i_in_data.glyph_offset;
        gl_wdata.w   = (i_in_data.glyph_width  > CAP_W) ? CAP_W : i_in_data.glyph_width;
        gl_wdata.h   = (i_in_data.glyph_height > CAP_W) ? CAP_W : i_in_data.glyph_height;
        gl_wdata.adv = i_in_data.glyph_advance;
        gl_wdata.xo  = i_in_data.glyph_x_offset;
        gl_wdata.yo  = i_in_data.glyph_y_offset;
    end

    // wrap test on the freshly read glyph
    logic signed [17:0] wrap_sum;
    assign wrap_sum = $signed({2'b00, r_col}) + 18'(gl_rdata.xo)
                    + $signed({12'd0, gl_rdata.w});

    // byte piece placement
    logic [5:0] room;
    logic [3:0] take;
    logic [6:0] pos;
    assign room = r_w - r_xx;
    assign take = ({2'b00, r_left} < room) ? r_left : room[3:0];

    logic [15:0] x0_c;
    logic [16:0] nxt_addr;
    logic        out_free;
    assign x0_c     = r_col + 16'(r_xo);
    assign nxt_addr = r_addr + 17'd1;
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state; n_col = r_col; n_row = r_row;
        n_w = r_w; n_h = r_h; n_adv = r_adv; n_xo = r_xo; n_yo = r_yo;
        n_addr = r_addr; n_x0 = r_x0; n_y = r_y; n_colmask = r_colmask;
        n_mask = r_mask; n_xx = r_xx; n_yy = r_yy; n_bits = r_bits; n_left = r_left;
        n_out = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        pos = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_in_data.func)
                        FN_SET_CURSOR: begin
                            n_col = i_in_data.new_x;
                            n_row = i_in_data.new_y;
                        end
                        FN_CHAR: begin
                            if (i_in_data.byte_value == CODE_LF) begin
                                n_col = '0;
                                n_row = r_row + 16'(r_line_advance);
                            end else if (code_ok) begin
                                n_state = S_SETUP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            // glyph record available
            S_SETUP: begin
                n_w = gl_rdata.w; n_h = gl_rdata.h; n_adv = gl_rdata.adv;
                n_xo = gl_rdata.xo; n_yo = gl_rdata.yo;
                n_addr = {5'd0, gl_rdata.offset};
                if (gl_rdata.w == '0 || gl_rdata.h == '0) begin
                    n_col = r_col + 16'(gl_rdata.adv);
                    n_state = S_IDLE;
                end else begin
                    if (r_wrap_enable && (wrap_sum > $signed({9'd0, r_screen_width}))) begin
                        n_col = '0;
                        n_row = r_row + 16'(r_line_advance);
                    end
                    n_state = S_CLIP;
                end
            end
            // row origin and column clip mask
            S_CLIP: begin
                n_x0 = x0_c;
                n_y  = r_row + 16'(r_yo);
                for (int i = 0; i < MASK_BITS; i++) begin
                    n_colmask[i] = (16'(x0_c + 16'(i)) < {7'd0, r_screen_width});
                end
                n_mask = '0; n_xx = '0; n_yy = '0; n_left = '0;
                n_state = S_REDUCE;
            end
            // offset modulo bitmap size
            S_REDUCE: begin
                if (r_addr >= BB_W) begin
                    n_addr = r_addr - BB_W;
                end else begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_LOADB;
            end
            S_LOADB: begin
                n_bits = bm_rdata;
                n_left = 4'd8;
                n_addr = (nxt_addr >= BB_W) ? '0 : nxt_addr;
                n_state = S_DRAW;
            end
            // move one byte piece into the row mask, msb first
            S_DRAW: begin
                for (int i = 0; i < 8; i++) begin
                    pos = 7'(r_xx) + 7'(i);
                    if (4'(i) < take && pos < 7'(MASK_BITS)) begin
                        n_mask[pos[4:0]] = r_bits[7 - i];
                    end
                end
                n_bits = r_bits << take;
                n_left = r_left - take;
                n_xx = r_xx + 6'(take);
                if (6'(take) == room) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FETCH;
                end
            end
            // hand the row to the output register
            S_EMIT: begin
                if (out_free) begin
                    n_out.row_x = r_x0;
                    n_out.row_y = r_y;
                    n_out.pixel_mask = (r_y < {7'd0, r_screen_height})
                                     ? (r_mask & r_colmask) : '0;
                    n_out.pixel_value = {r_text_color[7:0], r_text_color[15:8]};
                    n_out.last = (r_yy + 6'd1 == r_h);
                    n_out_valid = 1'b1;
                    n_mask = '0; n_xx = '0;
                    n_yy = r_yy + 6'd1;
                    n_y = r_y + 16'd1;
                    if (r_yy + 6'd1 == r_h) begin
                        n_col = r_col + 16'(r_adv);
                        n_state = S_IDLE;
                    end else if (r_left == '0) begin
                        n_state = S_FETCH;
                    end else begin
                        n_state = S_DRAW;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_col <= 16'd10;
            r_row <= 16'd10;
            r_out_valid <= 1'b0;
            r_left <= '0;
            r_xx <= '0;
            r_w <= '0;
        end else begin
            r_state <= n_state;
            r_col <= n_col;
            r_row <= n_row;
            r_out_valid <= n_out_valid;
            r_left <= n_left;
            r_xx <= n_xx;
            r_w <= n_w;
        end
        r_h <= n_h; r_adv <= n_adv; r_xo <= n_xo; r_yo <= n_yo;
        r_addr <= n_addr; r_x0 <= n_x0; r_y <= n_y; r_colmask <= n_colmask;
        r_mask <= n_mask; r_yy <= n_yy; r_bits <= n_bits; r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // checks
    `GTR_ASSERT_IMP(a_piece_in_row, i_clk, i_rst_n, r_state == S_DRAW, r_xx < r_w)
    `GTR_ASSERT_IMP(a_byte_bits, i_clk, i_rst_n, 1'b1, r_left <= 4'd8)
    `GTR_ASSERT_NXT(a_emit_shows, i_clk, i_rst_n, (r_state == S_EMIT) && out_free, o_out_valid)
    `GTR_ASSERT_NXT(a_busy_no_accept, i_clk, i_rst_n, r_state == S_DRAW, !o_in_ready)
endmodule

// ----- tb/sv/glyph_text_renderer_tb.sv -----
// testbench for the glyph text renderer: drives font loads, cursor moves and
// characters, predicts every glyph row and checks it; depends on gtr_pkg and rtl
module glyph_text_renderer_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gtr_pkg::*;

    // glyph row predictor and queue of rows still to arrive
    class glyph_row_board;
        logic [7:0]  bmp [0:4095];
        t_glyph_rec  glyphs [0:127];
        logic [15:0] col, row;
        logic [15:0] color;
        logic [8:0]  scr_w, scr_h;
        logic        wrap_on;
        logic [7:0]  first_c, last_c, line_adv;
        t_out_item   rows_due [$];
        int          errors;

        function void reset_state();
            col = 16'd10; row = 16'd10; color = 0; scr_w = 9'd240; scr_h = 9'd240;
            wrap_on = 0; first_c = 8'd32; last_c = 8'd126; line_adv = 0; errors = 0;
            for (int i = 0; i < 128; i++) glyphs[i] = '0;
            for (int i = 0; i < 4096; i++) bmp[i] = 8'h00;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_TEXT_COLOR:    color = val;
                CFG_SCREEN_WIDTH:  scr_w = val[8:0];
                CFG_SCREEN_HEIGHT: scr_h = val[8:0];
                CFG_WRAP_ENABLE:   wrap_on = val[0];
                CFG_FIRST_CODE:    first_c = val[7:0];
                CFG_LAST_CODE:     last_c = val[7:0];
                CFG_LINE_ADVANCE:  line_adv = val[7:0];
                default: ;
            endcase
        endfunction

        // note an accepted request and queue the rows it draws
        function void note_request(t_in_item r);
            t_glyph_rec g;
            int         idx, addr, bitcnt;
            logic [7:0] bits;
            logic [15:0] x0, y, x;
            logic [31:0] mask;
            t_out_item  o;
            bits = 0;
            case (r.func)
                FN_LOAD_BITMAP: bmp[r.slot] = r.byte_value;
                FN_LOAD_GLYPH: if (r.slot < 128) begin
                    g.offset = r.glyph_offset;
                    g.w = (r.glyph_width > 32) ? 6'd32 : r.glyph_width;
                    g.h = (r.glyph_height > 32) ? 6'd32 : r.glyph_height;
                    g.adv = r.glyph_advance;
                    g.xo = r.glyph_x_offset;
                    g.yo = r.glyph_y_offset;
                    glyphs[r.slot] = g;
                end
                FN_SET_CURSOR: begin
                    col = r.new_x; row = r.new_y;
                end
                default: begin
                    if (r.byte_value == CODE_LF) begin
                        col = 0; row = row + line_adv;
                    end else if (r.byte_value != CODE_CR && r.byte_value >= first_c &&
                                 r.byte_value <= last_c &&
                                 int'(r.byte_value) - int'(first_c) < 128) begin
                        idx = int'(r.byte_value) - int'(first_c);
                        g = glyphs[idx];
                        if (g.w != 0 && g.h != 0) begin
                            if (wrap_on && int'(col) + int'(g.xo) + int'(g.w) > int'(scr_w))
                            begin
                                col = 0; row = row + line_adv;
                            end
                            addr = g.offset;
                            bitcnt = 0;
                            x0 = col + 16'(signed'(g.xo));
                            for (int yy = 0; yy < g.h; yy++) begin
                                y = row + 16'(signed'(g.yo)) + 16'(yy);
                                mask = 0;
                                for (int xx = 0; xx < g.w; xx++) begin
                                    if (bitcnt % 8 == 0) begin
                                        bits = bmp[addr];
                                        addr = (addr + 1) % 4096;
                                    end
                                    bitcnt++;
                                    x = x0 + 16'(xx);
                                    if (bits[7] && x < scr_w && y < scr_h) mask[xx] = 1'b1;
                                    bits = bits << 1;
                                end
                                o.row_x = x0; o.row_y = y; o.pixel_mask = mask;
                                o.pixel_value = {color[7:0], color[15:8]};
                                o.last = (yy + 1 == g.h);
                                rows_due.push_back(o);
                            end
                        end
                        col = col + g.adv;
                    end
                end
            endcase
        endfunction

        // compare one emitted row with the oldest prediction
        function void check_row(t_out_item got);
            t_out_item e;
            if (rows_due.size() == 0) begin
                $display("%0t: unexpected row, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            e = rows_due.pop_front();
            if (got.row_x !== e.row_x)
                $display("%0t: row_x expected %h actual %h", $time, e.row_x, got.row_x);
            if (got.row_y !== e.row_y)
                $display("%0t: row_y expected %h actual %h", $time, e.row_y, got.row_y);
            if (got.pixel_mask !== e.pixel_mask)
                $display("%0t: pixel_mask expected %h actual %h", $time, e.pixel_mask,
                         got.pixel_mask);
            if (got.pixel_value !== e.pixel_value)
                $display("%0t: pixel_value expected %h actual %h", $time, e.pixel_value,
                         got.pixel_value);
            if (got.last !== e.last)
                $display("%0t: last expected %b actual %b", $time, e.last, got.last);
            if (got !== e) errors++;
        endfunction
    endclass

    logic       clk, rst_n, in_valid, in_ready, out_valid, out_ready, cfg_we;
    t_in_item   in_data;
    t_out_item  out_data;
    logic [2:0] cfg_index;
    logic [15:0] cfg_data;
    glyph_row_board board;
    int         idle_cycles;
    bit         loaded [0:4095];

    glyph_text_renderer i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    always begin
        clk = 1'b0; #6;
        clk = 1'b1; #6;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: random stalls, check on each accepted row
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) board.check_row(out_data);
    end
    initial begin
        int g;
        out_ready = 1'b0;
        forever begin
            @(negedge clk);
            g = gap_len();
            out_ready = (g == 0);
            repeat (g) @(negedge clk);
            out_ready = 1'b1;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 20000) begin
            $display("glyph_text_renderer: mismatch");
            $finish;
        end
    end

    task automatic send(t_in_item r);
        repeat (gap_len()) @(negedge clk);
        in_data = r;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        board.note_request(r);
        if (r.func == FN_LOAD_BITMAP) loaded[r.slot] = 1'b1;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic write_cfg(logic [2:0] idx, logic [15:0] val);
        while (board.rows_due.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
        @(posedge clk);
        board.write_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic t_in_item noise();
        t_in_item r;
        r = t_in_item'($bits(t_in_item)'({$urandom, $urandom, $urandom, $urandom}));
        return r;
    endfunction

    task automatic put_byte(int a, logic [7:0] v);
        t_in_item r;
        r = noise(); r.func = FN_LOAD_BITMAP; r.slot = 12'(a); r.byte_value = v;
        send(r);
    endtask

    // load one glyph record into slot s with the given bitmap offset
    task automatic put_glyph(int s, int w, int h, int adv, int xo, int yo, int off);
        t_in_item r;
        r = noise(); r.func = FN_LOAD_GLYPH; r.slot = 12'(s);
        r.glyph_offset = 12'(off); r.glyph_width = 6'(w); r.glyph_height = 6'(h);
        r.glyph_advance = 8'(adv); r.glyph_x_offset = 8'(xo); r.glyph_y_offset = 8'(yo);
        send(r);
    endtask

    task automatic put_char(int c);
        t_in_item r;
        r = noise(); r.func = FN_CHAR; r.byte_value = 8'(c);
        send(r);
    endtask

    task automatic put_cursor(int x, int y);
        t_in_item r;
        r = noise(); r.func = FN_SET_CURSOR; r.new_x = 16'(x); r.new_y = 16'(y);
        send(r);
    endtask

    // random glyph record with a bitmap inside the loaded region
    task automatic rand_glyph(int s);
        int w, h, off;
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(33, 63) : $urandom_range(0, 12);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
        off = $urandom_range(0, 63);
        put_glyph(s, w, h, $urandom_range(0, 255), $urandom_range(0, 255) - 128,
                  $urandom_range(0, 255) - 128, off);
    endtask

    initial begin
        int n, s, c;
        t_in_item r;
        board = new();
        board.reset_state();
        in_valid = 0; in_data = '0; cfg_we = 0; cfg_index = CFG_TEXT_COLOR; cfg_data = 0;
        idle_cycles = 0;
        rst_n = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // bitmap: bytes 0..191 and the top end for offset wrap
        for (int a = 0; a < 192; a++) put_byte(a, 8'($urandom));
        for (int a = 4090; a < 4096; a++) put_byte(a, 8'($urandom));
        put_byte(0, 8'hff); put_byte(1, 8'h00);
        // every glyph slot gets a defined record
        for (s = 0; s < 128; s++) rand_glyph(s);

        // directed: extremes, wrap across store end, special codes
        write_cfg(CFG_TEXT_COLOR, 16'h12ab);
        put_glyph(0, 32, 32, 255, 127, -128, 4090);
        put_glyph(1, 63, 1, 0, -128, 127, 0);
        put_glyph(2, 0, 5, 7, 0, 0, 0);
        put_glyph(3, 1, 0, 9, 0, 0, 0);
        put_glyph(4095, 5, 5, 5, 0, 0, 0);
        put_char(32); put_char(33); put_char(34); put_char(35);
        put_char(8'h0a); put_char(8'h0d); put_char(31); put_char(127);
        put_cursor(65535, 65535); put_char(32);
        put_cursor(0, 0); put_char(33);
        write_cfg(CFG_WRAP_ENABLE, 16'd1);
        write_cfg(CFG_LINE_ADVANCE, 16'd255);
        write_cfg(CFG_SCREEN_WIDTH, 16'd1);
        write_cfg(CFG_SCREEN_HEIGHT, 16'd320);
        put_cursor(200, 5); put_char(33); put_char(8'h0a); put_char(36);
        write_cfg(CFG_FIRST_CODE, 16'd0);
        write_cfg(CFG_LAST_CODE, 16'd255);
        put_char(0); put_char(200); put_char(127);

        // random phases over several settings
        for (int ph = 0; ph < 6; ph++) begin
            write_cfg(CFG_TEXT_COLOR, 16'($urandom));
            write_cfg(CFG_SCREEN_WIDTH, ph == 0 ? 16'd320 : 16'($urandom_range(1, 320)));
            write_cfg(CFG_SCREEN_HEIGHT, ph == 1 ? 16'd1 : 16'($urandom_range(1, 320)));
            write_cfg(CFG_WRAP_ENABLE, 16'(ph % 2));
            write_cfg(CFG_FIRST_CODE, ph == 2 ? 16'd255 : 16'($urandom_range(0, 64)));
            write_cfg(CFG_LAST_CODE, ph == 3 ? 16'd0 : 16'($urandom_range(100, 255)));
            write_cfg(CFG_LINE_ADVANCE, 16'($urandom_range(0, 255)));
            for (n = 0; n < 12; n++) begin
                c = $urandom_range(0, 99);
                if (c < 65) put_char($urandom_range(0, 9) == 0 ? 8'h0a :
                                     board.first_c + $urandom_range(0, 40));
                else if (c < 75) put_cursor($urandom_range(0, 99) < 80 ?
                                            $urandom_range(0, 330) : $urandom,
                                            $urandom_range(0, 99) < 80 ?
                                            $urandom_range(0, 330) : $urandom);
                else if (c < 85) rand_glyph($urandom_range(0, 127));
                else if (c < 95) put_byte($urandom_range(0, 255), 8'($urandom));
                else begin
                    // glyph loads to out-of-range slots, bitmap loads above byte 255 and other random requests
                    r = noise();
                    if (r.func == FN_LOAD_GLYPH && r.slot < 128) r.slot = 12'd200;
                    if (r.func == FN_LOAD_BITMAP && !loaded[r.slot] && r.slot < 256)
                        r.slot = 12'd300;
                    if (r.func == FN_LOAD_BITMAP) r.slot[11:8] = r.slot[11:8] | 4'h1;
                    send(r);
                end
            end
        end

        while (board.rows_due.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (board.errors == 0 && board.rows_due.size() == 0)
            $display("glyph_text_renderer: match");
        else
            $display("glyph_text_renderer: mismatch");
        $finish;
    end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/gtr_pkg.sv
rtl/gtr_bitmap_store.sv
rtl/gtr_glyph_store.sv
rtl/glyph_text_renderer.sv
tb/sv/glyph_text_renderer_tb.sv
